FILE: sv/wst_pkg.sv
// Shared types, codes and constants of the workout session tracker.
`default_nettype none

package wst_pkg;

    localparam int OP_W         = 3;
    localparam int KIND_W       = 2;
    localparam int PED_W        = 16;
    localparam int HR_W         = 8;
    localparam int MODE_W       = 2;
    localparam int SEC_W        = 24;
    localparam int KCAL_W       = 16;
    localparam int DAY_W        = 8;
    localparam int SLOT_W       = 3;
    localparam int WEIGHT_W     = 8;
    localparam int HRSUM_W      = 24;
    localparam int SAMPLE_W     = 16;
    localparam int MET_W        = 5;
    localparam int ADD_W        = WEIGHT_W + MET_W;
    localparam int KREM_W       = 14;
    localparam int KACC_W       = KREM_W + 1;
    localparam int SECMIN_W     = 6;
    localparam int DIV_CNT_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
    localparam logic [OP_W-1:0] OP_DATE   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_RUN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RIDE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ALT  = 2'd3;

    localparam logic [MET_W-1:0] MET_RUN  = 5'd16;
    localparam logic [MET_W-1:0] MET_WALK = 5'd7;
    localparam logic [MET_W-1:0] MET_RIDE = 5'd12;

    localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET = 8'd60;
    localparam logic [HR_W-1:0]      HR_LOW       = 8'd40;
    localparam logic [HR_W-1:0]      HR_HIGH      = 8'd200;
    localparam logic [SEC_W-1:0]     SEC_MAX      = 24'hFFFFFF;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX   = 16'hFFFF;
    localparam logic [KCAL_W-1:0]    KCAL_MAX     = 16'hFFFF;
    localparam logic [DAY_W-1:0]     BYTE_MAX     = 8'd255;
    localparam logic [KACC_W-1:0]    KCAL_UNIT    = KACC_W'(144 * 100);
    localparam logic [SECMIN_W-1:0]  SEC_LAST     = 6'd59;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST     = 3'd7;

    localparam logic REG_WEIGHT = 1'b0;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
    } wst_cmd_t;

    typedef struct packed {
        logic div_needed;
    } wst_status_t;

    function automatic logic [MET_W-1:0] met_x2(input logic [KIND_W-1:0] kind);
        logic [MET_W-1:0] met;
        case (kind)
            KIND_WALK: met = MET_WALK;
            KIND_RIDE: met = MET_RIDE;
            default:   met = MET_RUN;
        endcase
        return met;
    endfunction

endpackage

`default_nettype wire

FILE: sv/wst_item_if.sv
// Request channel carrying one tracker command.
`default_nettype none

interface wst_item_if
    import wst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [KIND_W-1:0]   sport_kind;
    logic [PED_W-1:0]    pedometer_count;
    logic [HR_W-1:0]     heart_rate;

    modport source (output valid, op, sport_kind, pedometer_count, heart_rate, input ready);
    modport sink   (input valid, op, sport_kind, pedometer_count, heart_rate, output ready);
endinterface

`default_nettype wire

FILE: sv/wst_result_if.sv
// Result channel carrying one tracker status report.
`default_nettype none

interface wst_result_if
    import wst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   session_state;
    logic [SEC_W-1:0]    session_seconds;
    logic [PED_W-1:0]    session_steps;
    logic [HR_W-1:0]     current_hr;
    logic [HR_W-1:0]     average_hr;
    logic [KCAL_W-1:0]   session_kcal;
    logic [DAY_W-1:0]    today_minutes;
    logic [DAY_W-1:0]    today_kcal;
    logic                record_write;
    logic [SLOT_W-1:0]   record_slot;
    logic [DAY_W-1:0]    record_minutes;
    logic [DAY_W-1:0]    record_kcal;

    modport source (output valid, session_state, session_seconds, session_steps, current_hr,
                    average_hr, session_kcal, today_minutes, today_kcal, record_write,
                    record_slot, record_minutes, record_kcal, input ready);
    modport sink   (input valid, session_state, session_seconds, session_steps, current_hr,
                    average_hr, session_kcal, today_minutes, today_kcal, record_write,
                    record_slot, record_minutes, record_kcal, output ready);
endinterface

`default_nettype wire

FILE: sv/wst_ctrl.sv
// Controller state machine sequencing accept, average division and report.
`default_nettype none

module wst_ctrl
    import wst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  wire logic        result_ready,
    input  wire wst_status_t status,
    output wst_cmd_t         cmd
);

    localparam logic [1:0] S_WAIT = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        item_ready   = 1'b0;
        result_valid = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_WAIT:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.div_needed ? S_DIV : S_SEND;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = (cnt_reg == DIV_LAST);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    state_next = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WAIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wst_datapath.sv
// Session, daily and record state with the serial heart-rate average divider.
`default_nettype none

module wst_datapath
    import wst_pkg::*;
#(
    parameter int RECORD_SLOTS = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wst_cmd_t            cmd,
    output wst_status_t              status,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [KIND_W-1:0]   sport_kind,
    input  wire logic [PED_W-1:0]    pedometer_count,
    input  wire logic [HR_W-1:0]     heart_rate,
    output logic [MODE_W-1:0]        session_state,
    output logic [SEC_W-1:0]         session_seconds,
    output logic [PED_W-1:0]         session_steps,
    output logic [HR_W-1:0]          current_hr,
    output logic [HR_W-1:0]          average_hr,
    output logic [KCAL_W-1:0]        session_kcal,
    output logic [DAY_W-1:0]         today_minutes,
    output logic [DAY_W-1:0]         today_kcal,
    output logic                     record_write,
    output logic [SLOT_W-1:0]        record_slot,
    output logic [DAY_W-1:0]         record_minutes,
    output logic [DAY_W-1:0]         record_kcal
);

    localparam int RING_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam logic [RING_W-1:0] RING_LAST = RING_W'(RECORD_SLOTS - 1);

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [PED_W-1:0]    start_reg, start_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic                half_reg, half_next;
    logic [SECMIN_W-1:0] secmin_reg, secmin_next;
    logic [DAY_W-1:0]    min_reg, min_next;
    logic [PED_W-1:0]    steps_reg, steps_next;
    logic [HR_W-1:0]     last_hr_reg, last_hr_next;
    logic [HRSUM_W-1:0]  hr_sum_reg, hr_sum_next;
    logic [SAMPLE_W-1:0] samples_reg, samples_next;
    logic [HR_W-1:0]     mean_reg, mean_next;
    logic [KCAL_W-1:0]   kcal_reg, kcal_next;
    logic [KREM_W-1:0]   krem_reg, krem_next;
    logic [DAY_W-1:0]    day_min_reg, day_min_next;
    logic [DAY_W-1:0]    day_kcal_reg, day_kcal_next;
    logic [RING_W-1:0]   ring_reg, ring_next;
    logic                rec_w_reg, rec_w_next;
    logic [SLOT_W-1:0]   rec_slot_reg, rec_slot_next;
    logic [DAY_W-1:0]    rec_min_reg, rec_min_next;
    logic [DAY_W-1:0]    rec_kcal_reg, rec_kcal_next;

    logic [PED_W-1:0]    div_rem_reg, div_rem_next;
    logic [HR_W-1:0]     div_q_reg, div_q_next;
    logic [PED_W:0]      div_trial;
    logic                div_fit;

    logic                is_run;
    logic                sample_ok;
    logic [ADD_W-1:0]    energy_add;
    logic [KACC_W-1:0]   kacc;
    logic [DAY_W-1:0]    kcal_sat8;
    logic [DAY_W:0]      day_min_sum;
    logic [DAY_W:0]      day_kcal_sum;
    logic [RING_W+SLOT_W-1:0] ring_wide;

    assign is_run    = (mode_reg == MODE_RUN);
    assign sample_ok = (heart_rate >= HR_LOW) && (heart_rate <= HR_HIGH)
                       && (samples_reg != SAMPLE_MAX);
    assign status.div_needed = (op == OP_TICK) && is_run && sample_ok;

    assign energy_add   = ADD_W'(weight) * ADD_W'(met_x2(kind_reg));
    assign kacc         = KACC_W'(krem_reg) + KACC_W'(energy_add);
    assign kcal_sat8    = (kcal_reg > KCAL_W'(BYTE_MAX)) ? BYTE_MAX : kcal_reg[DAY_W-1:0];
    assign day_min_sum  = {1'b0, day_min_reg} + {1'b0, min_reg};
    assign day_kcal_sum = {1'b0, day_kcal_reg} + {1'b0, kcal_sat8};
    assign ring_wide    = {{SLOT_W{1'b0}}, ring_reg};

    always_comb
    begin
        mode_next     = mode_reg;
        kind_next     = kind_reg;
        start_next    = start_reg;
        sec_next      = sec_reg;
        half_next     = half_reg;
        secmin_next   = secmin_reg;
        min_next      = min_reg;
        steps_next    = steps_reg;
        last_hr_next  = last_hr_reg;
        hr_sum_next   = hr_sum_reg;
        samples_next  = samples_reg;
        mean_next     = mean_reg;
        kcal_next     = kcal_reg;
        krem_next     = krem_reg;
        day_min_next  = day_min_reg;
        day_kcal_next = day_kcal_reg;
        ring_next     = ring_reg;
        rec_w_next    = 1'b0;
        rec_slot_next = '0;
        rec_min_next  = '0;
        rec_kcal_next = '0;
        case (op)
            OP_TICK:
            begin
                if (is_run)
                begin
                    half_next = ~half_reg;
                    if (half_reg && (sec_reg != SEC_MAX))
                    begin
                        sec_next = sec_reg + 1'b1;
                        if (secmin_reg == SEC_LAST)
                        begin
                            secmin_next = '0;
                            if (min_reg != BYTE_MAX)
                            begin
                                min_next = min_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            secmin_next = secmin_reg + 1'b1;
                        end
                    end
                    steps_next   = pedometer_count - start_reg;
                    last_hr_next = heart_rate;
                    if (sample_ok)
                    begin
                        hr_sum_next  = hr_sum_reg + HRSUM_W'(heart_rate);
                        samples_next = samples_reg + 1'b1;
                    end
                    if (kacc >= KCAL_UNIT)
                    begin
                        krem_next = KREM_W'(kacc - KCAL_UNIT);
                        if (kcal_reg != KCAL_MAX)
                        begin
                            kcal_next = kcal_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        krem_next = KREM_W'(kacc);
                    end
                end
            end
            OP_START:
            begin
                sec_next     = '0;
                half_next    = 1'b0;
                secmin_next  = '0;
                min_next     = '0;
                steps_next   = '0;
                last_hr_next = '0;
                hr_sum_next  = '0;
                samples_next = '0;
                mean_next    = '0;
                kcal_next    = '0;
                krem_next    = '0;
                kind_next    = (sport_kind == KIND_ALT) ? KIND_RUN : sport_kind;
                mode_next    = MODE_RUN;
                start_next   = pedometer_count;
            end
            OP_PAUSE:
            begin
                if (is_run)
                begin
                    mode_next = MODE_PAUSE;
                end
            end
            OP_RESUME:
            begin
                if (mode_reg == MODE_PAUSE)
                begin
                    mode_next = MODE_RUN;
                end
            end
            OP_STOP:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    mode_next     = MODE_IDLE;
                    day_min_next  = day_min_sum[DAY_W] ? BYTE_MAX : day_min_sum[DAY_W-1:0];
                    day_kcal_next = day_kcal_sum[DAY_W] ? BYTE_MAX : day_kcal_sum[DAY_W-1:0];
                    if (min_reg != '0)
                    begin
                        rec_w_next    = 1'b1;
                        rec_slot_next = ring_wide[SLOT_W-1:0];
                        rec_min_next  = min_reg;
                        rec_kcal_next = kcal_sat8;
                        ring_next     = (ring_reg == RING_LAST) ? '0 : ring_reg + 1'b1;
                    end
                end
            end
            OP_DATE:
            begin
                day_min_next  = '0;
                day_kcal_next = '0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // restoring division of the heart-rate sum by the sample count, one quotient bit a cycle
    assign div_trial    = {div_rem_reg, div_q_reg[HR_W-1]};
    assign div_fit      = (div_trial >= {1'b0, samples_reg});
    assign div_rem_next = div_fit ? PED_W'(div_trial - {1'b0, samples_reg})
                                  : div_trial[PED_W-1:0];
    assign div_q_next   = {div_q_reg[HR_W-2:0], div_fit};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_rem_reg <= hr_sum_next[HRSUM_W-1:HR_W];
            div_q_reg   <= hr_sum_next[HR_W-1:0];
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_rem_next;
            div_q_reg   <= div_q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            kind_reg     <= KIND_RUN;
            start_reg    <= '0;
            sec_reg      <= '0;
            half_reg     <= 1'b0;
            secmin_reg   <= '0;
            min_reg      <= '0;
            steps_reg    <= '0;
            last_hr_reg  <= '0;
            hr_sum_reg   <= '0;
            samples_reg  <= '0;
            mean_reg     <= '0;
            kcal_reg     <= '0;
            krem_reg     <= '0;
            day_min_reg  <= '0;
            day_kcal_reg <= '0;
            ring_reg     <= '0;
            rec_w_reg    <= 1'b0;
            rec_slot_reg <= '0;
            rec_min_reg  <= '0;
            rec_kcal_reg <= '0;
        end
        else if (cmd.load)
        begin
            mode_reg     <= mode_next;
            kind_reg     <= kind_next;
            start_reg    <= start_next;
            sec_reg      <= sec_next;
            half_reg     <= half_next;
            secmin_reg   <= secmin_next;
            min_reg      <= min_next;
            steps_reg    <= steps_next;
            last_hr_reg  <= last_hr_next;
            hr_sum_reg   <= hr_sum_next;
            samples_reg  <= samples_next;
            mean_reg     <= mean_next;
            kcal_reg     <= kcal_next;
            krem_reg     <= krem_next;
            day_min_reg  <= day_min_next;
            day_kcal_reg <= day_kcal_next;
            ring_reg     <= ring_next;
            rec_w_reg    <= rec_w_next;
            rec_slot_reg <= rec_slot_next;
            rec_min_reg  <= rec_min_next;
            rec_kcal_reg <= rec_kcal_next;
        end
        else if (cmd.div_last)
        begin
            mean_reg <= div_q_next;
        end
    end

    assign session_state   = mode_reg;
    assign session_seconds = sec_reg;
    assign session_steps   = steps_reg;
    assign current_hr      = last_hr_reg;
    assign average_hr      = mean_reg;
    assign session_kcal    = kcal_reg;
    assign today_minutes   = day_min_reg;
    assign today_kcal      = day_kcal_reg;
    assign record_write    = rec_w_reg;
    assign record_slot     = rec_slot_reg;
    assign record_minutes  = rec_min_reg;
    assign record_kcal     = rec_kcal_reg;

endmodule

`default_nettype wire

FILE: sv/workout_session_tracker_unit.sv
// Top level of the workout session tracker: channels, weight register, controller, datapath.
//
//  port     role      handshake            content
//  item     sink      valid/ready          op, sport_kind, pedometer_count, heart_rate
//  result   source    valid/ready          session status and history record
//  psel...  slave     APB, pready high     body_weight_kg at byte address 0
//
// An item goes from accept to the result state; a running tick with an averaged heart rate
// first passes the 8-step restoring divider, which computes the mean one bit a cycle.
// One item is in work at a time; item.ready stays low until the result is taken.
// Reset is asynchronous and clears all state but the divider registers at once, with no clearing pass.
`default_nettype none

module workout_session_tracker_unit
    import wst_pkg::*;
#(
    parameter int RECORD_SLOTS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wst_item_if.sink                   item,
    wst_result_if.source               result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [WEIGHT_W-1:0] weight_reg;
    wst_cmd_t            cmd;
    wst_status_t         status;

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_WEIGHT) ? CFG_DATA_W'(weight_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[CFG_ADDR_W-1] == REG_WEIGHT))
        begin
            weight_reg <= pwdata[WEIGHT_W-1:0];
        end
    end

    wst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    wst_datapath #(
        .RECORD_SLOTS (RECORD_SLOTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .weight          (weight_reg),
        .op              (item.op),
        .sport_kind      (item.sport_kind),
        .pedometer_count (item.pedometer_count),
        .heart_rate      (item.heart_rate),
        .session_state   (result.session_state),
        .session_seconds (result.session_seconds),
        .session_steps   (result.session_steps),
        .current_hr      (result.current_hr),
        .average_hr      (result.average_hr),
        .session_kcal    (result.session_kcal),
        .today_minutes   (result.today_minutes),
        .today_kcal      (result.today_kcal),
        .record_write    (result.record_write),
        .record_slot     (result.record_slot),
        .record_minutes  (result.record_minutes),
        .record_kcal     (result.record_kcal)
    );

endmodule

`default_nettype wire
